@@ hw/rtl/rtg_pkg.sv @@
// Shared constants and types for the radiance tonemap / gamma pixel pipeline.
package rtg_pkg;

    localparam int CHANNELS    = 3;   // red, green, blue
    localparam int SAMPLE_BITS = 16;  // sample count width
    localparam int TONE_BITS   = 16;  // Reinhard result, Q0.16
    localparam int PIX_BITS    = 8;   // display channel width

    localparam logic [PIX_BITS-1:0] ALPHA = 8'hFF;

    typedef logic [PIX_BITS-1:0] t_pix;

endpackage

@@ hw/rtl/radiance_tonemap_gamma_rgba.sv @@
// Radiance to RGBA8 pipeline: average, Reinhard tonemap, gamma 1/2.2, pack.
// Stages in order: capture, sample-count divide, Reinhard divisor, Reinhard divide, gamma search.
// One transaction per cycle unless stalled; every stage is registered and advances together.
// A stall on the output freezes the whole pipe; nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous) clears the stage valid bits only; data regs are not reset.
// No memories, no startup sweep: the block takes input right after reset.
module radiance_tonemap_gamma_rgba #(
    parameter int RADIANCE_BITS      = 32,
    parameter int RADIANCE_FRAC_BITS = 12,
    parameter int GAMMA_INDEX_BITS   = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [RADIANCE_BITS-1:0] i_red_radiance,
    input  logic [RADIANCE_BITS-1:0] i_green_radiance,
    input  logic [RADIANCE_BITS-1:0] i_blue_radiance,
    input  logic [15:0]              i_sample_count,
    input  logic                     i_last_in_tile,
    // output channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [31:0]              o_pixel_rgba,
    output logic                     o_tile_done
);

    localparam int RB    = RADIANCE_BITS;
    localparam int F     = RADIANCE_FRAC_BITS;
    localparam int G     = GAMMA_INDEX_BITS;
    localparam int NCH   = rtg_pkg::CHANNELS;
    localparam int SB    = rtg_pkg::SAMPLE_BITS;
    localparam int QB    = rtg_pkg::TONE_BITS;
    localparam int GS    = rtg_pkg::PIX_BITS;   // one gamma search stage per output bit
    localparam int THR_W = G + 1;               // a threshold can reach 2^G

    // Gamma thresholds: entry v is the smallest idx with
    // v^11 * 2^(5G) <= 255^11 * idx^5. Output for idx is the largest v whose
    // threshold is <= idx, so the table is monotone and binary-searchable.
    // Built exactly with wide integers at elaboration.
    function automatic logic [256*THR_W-1:0] build_thr();
        logic [256*THR_W-1:0] tbl;
        logic [159:0]         k255;
        logic [159:0]         lhs;
        logic [159:0]         rhs;
        logic [159:0]         p5;
        int                   lo;
        int                   hi;
        int                   mid;
        tbl  = '0;
        k255 = 160'd1;
        for (int k = 0; k < 11; k++) begin
            k255 = k255 * 160'd255;
        end
        for (int v = 0; v < 256; v++) begin
            lhs = 160'd1;
            for (int k = 0; k < 11; k++) begin
                lhs = lhs * 160'(v);
            end
            lhs = lhs << (5 * G);
            lo  = 0;
            hi  = 1 << G;
            for (int it = 0; it < G + 2; it++) begin
                if (lo < hi) begin
                    mid = (lo + hi) >> 1;
                    p5  = 160'd1;
                    for (int k = 0; k < 5; k++) begin
                        p5 = p5 * 160'(mid);
                    end
                    rhs = k255 * p5;
                    if (lhs <= rhs) begin
                        hi = mid;
                    end else begin
                        lo = mid + 1;
                    end
                end
            end
            tbl[v*THR_W +: THR_W] = THR_W'(lo);
        end
        return tbl;
    endfunction

    localparam logic [256*THR_W-1:0] GAMMA_THR = build_thr();

    // ------------------------------------------------------------------
    // Global advance: the pipe moves unless a finished result is held.
    // ------------------------------------------------------------------
    logic advance;

    // Stage A: capture, sample count zero forced to one
    logic [RB-1:0] r_a_w [NCH];
    logic [SB-1:0] r_a_n;
    logic          r_a_last;
    logic          r_a_v;
    logic [RB-1:0] n_a_w [NCH];
    logic [SB-1:0] n_a_n;

    // Divide by sample count: one quotient bit per stage, restoring.
    // w holds the unconsumed dividend bits on top, quotient bits below.
    logic [SB-1:0] r_q1_rem  [RB][NCH];
    logic [RB-1:0] r_q1_w    [RB][NCH];
    logic [SB-1:0] r_q1_n    [RB];
    logic          r_q1_last [RB];
    logic          r_q1_v    [RB];
    logic [SB-1:0] n_q1_rem  [RB][NCH];
    logic [RB-1:0] n_q1_w    [RB][NCH];

    // Stage D: Reinhard divisor avg + 1.0; remainder starts at avg
    logic [RB:0]   r_d_rem [NCH];
    logic [RB:0]   r_d_den [NCH];
    logic          r_d_last;
    logic          r_d_v;
    logic [RB:0]   n_d_rem [NCH];
    logic [RB:0]   n_d_den [NCH];

    // Reinhard divide: (avg << 16) / (avg + 1.0), 16 quotient bits, one per stage
    logic [RB:0]   r_q2_rem  [QB][NCH];
    logic [RB:0]   r_q2_den  [QB][NCH];
    logic [QB-1:0] r_q2_q    [QB][NCH];
    logic          r_q2_last [QB];
    logic          r_q2_v    [QB];
    logic [RB:0]   n_q2_rem  [QB][NCH];
    logic [QB-1:0] n_q2_q    [QB][NCH];

    // Gamma: binary search over the threshold table, one output bit per stage
    logic [G-1:0]      r_g_idx  [GS][NCH];
    rtg_pkg::t_pix     r_g_val  [GS][NCH];
    logic              r_g_last [GS];
    logic              r_g_v    [GS];
    rtg_pkg::t_pix     n_g_val  [GS][NCH];

    logic [RB-1:0] in_rad [NCH];

    assign advance = !(r_g_v[GS-1] && i_stall);
    assign o_stall = !advance;

    assign in_rad[0] = i_red_radiance;
    assign in_rad[1] = i_green_radiance;
    assign in_rad[2] = i_blue_radiance;

    // ------------------------------------------------------------------
    // Stage A
    // ------------------------------------------------------------------
    always_comb begin
        n_a_n = (i_sample_count == '0) ? SB'(1) : i_sample_count;
        for (int c = 0; c < NCH; c++) begin
            n_a_w[c] = in_rad[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (advance) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_w    <= n_a_w;
            r_a_n    <= n_a_n;
            r_a_last <= i_last_in_tile;
        end
    end

    // ------------------------------------------------------------------
    // Divide by sample count
    // ------------------------------------------------------------------
    for (genvar gj = 0; gj < RB; gj++) begin : g_q1
        logic [SB-1:0] src_rem [NCH];
        logic [RB-1:0] src_w   [NCH];
        logic [SB-1:0] src_n;
        logic          src_last;
        logic          src_v;

        if (gj == 0) begin : g_head
            always_comb begin
                src_n    = r_a_n;
                src_last = r_a_last;
                src_v    = r_a_v;
                for (int c = 0; c < NCH; c++) begin
                    src_rem[c] = '0;
                    src_w[c]   = r_a_w[c];
                end
            end
        end else begin : g_body
            always_comb begin
                src_n    = r_q1_n[gj-1];
                src_last = r_q1_last[gj-1];
                src_v    = r_q1_v[gj-1];
                for (int c = 0; c < NCH; c++) begin
                    src_rem[c] = r_q1_rem[gj-1][c];
                    src_w[c]   = r_q1_w[gj-1][c];
                end
            end
        end

        always_comb begin
            logic [SB:0] trial;
            logic [SB:0] diff;
            for (int c = 0; c < NCH; c++) begin
                trial = {src_rem[c], src_w[c][RB-1]};
                diff  = trial - {1'b0, src_n};
                if (trial >= {1'b0, src_n}) begin
                    n_q1_rem[gj][c] = diff[SB-1:0];
                    n_q1_w[gj][c]   = {src_w[c][RB-2:0], 1'b1};
                end else begin
                    n_q1_rem[gj][c] = trial[SB-1:0];
                    n_q1_w[gj][c]   = {src_w[c][RB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q1_v[gj] <= 1'b0;
            end else if (advance) begin
                r_q1_v[gj] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_q1_rem[gj]  <= n_q1_rem[gj];
                r_q1_w[gj]    <= n_q1_w[gj];
                r_q1_n[gj]    <= src_n;
                r_q1_last[gj] <= src_last;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage D: divisor for the Reinhard curve
    // ------------------------------------------------------------------
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            n_d_rem[c] = {1'b0, r_q1_w[RB-1][c]};
            n_d_den[c] = {1'b0, r_q1_w[RB-1][c]} + ((RB+1)'(1) << F);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (advance) begin
            r_d_v <= r_q1_v[RB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_d_rem  <= n_d_rem;
            r_d_den  <= n_d_den;
            r_d_last <= r_q1_last[RB-1];
        end
    end

    // ------------------------------------------------------------------
    // Reinhard divide; avg < divisor so the quotient fits 16 bits
    // ------------------------------------------------------------------
    for (genvar gm = 0; gm < QB; gm++) begin : g_q2
        logic [RB:0]   src_rem [NCH];
        logic [RB:0]   src_den [NCH];
        logic [QB-1:0] src_q   [NCH];
        logic          src_last;
        logic          src_v;

        if (gm == 0) begin : g_head
            always_comb begin
                src_last = r_d_last;
                src_v    = r_d_v;
                for (int c = 0; c < NCH; c++) begin
                    src_rem[c] = r_d_rem[c];
                    src_den[c] = r_d_den[c];
                    src_q[c]   = '0;
                end
            end
        end else begin : g_body
            always_comb begin
                src_last = r_q2_last[gm-1];
                src_v    = r_q2_v[gm-1];
                for (int c = 0; c < NCH; c++) begin
                    src_rem[c] = r_q2_rem[gm-1][c];
                    src_den[c] = r_q2_den[gm-1][c];
                    src_q[c]   = r_q2_q[gm-1][c];
                end
            end
        end

        always_comb begin
            logic [RB+1:0] trial;
            logic [RB+1:0] diff;
            for (int c = 0; c < NCH; c++) begin
                trial = {src_rem[c], 1'b0};
                diff  = trial - {1'b0, src_den[c]};
                if (trial >= {1'b0, src_den[c]}) begin
                    n_q2_rem[gm][c] = diff[RB:0];
                    n_q2_q[gm][c]   = {src_q[c][QB-2:0], 1'b1};
                end else begin
                    n_q2_rem[gm][c] = trial[RB:0];
                    n_q2_q[gm][c]   = {src_q[c][QB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q2_v[gm] <= 1'b0;
            end else if (advance) begin
                r_q2_v[gm] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_q2_rem[gm]  <= n_q2_rem[gm];
                r_q2_den[gm]  <= src_den;
                r_q2_q[gm]    <= n_q2_q[gm];
                r_q2_last[gm] <= src_last;
            end
        end
    end

    // ------------------------------------------------------------------
    // Gamma search, MSB first; the last stage is the output register
    // ------------------------------------------------------------------
    for (genvar gb = 0; gb < GS; gb++) begin : g_gam
        localparam rtg_pkg::t_pix TRY_BIT = GS'(1) << (GS - 1 - gb);

        logic [G-1:0]  src_idx [NCH];
        rtg_pkg::t_pix src_val [NCH];
        logic          src_last;
        logic          src_v;

        if (gb == 0) begin : g_head
            always_comb begin
                src_last = r_q2_last[QB-1];
                src_v    = r_q2_v[QB-1];
                for (int c = 0; c < NCH; c++) begin
                    src_idx[c] = r_q2_q[QB-1][c][QB-1 -: G];
                    src_val[c] = '0;
                end
            end
        end else begin : g_body
            always_comb begin
                src_last = r_g_last[gb-1];
                src_v    = r_g_v[gb-1];
                for (int c = 0; c < NCH; c++) begin
                    src_idx[c] = r_g_idx[gb-1][c];
                    src_val[c] = r_g_val[gb-1][c];
                end
            end
        end

        always_comb begin
            rtg_pkg::t_pix    cand;
            logic [THR_W-1:0] thr;
            for (int c = 0; c < NCH; c++) begin
                cand = src_val[c] | TRY_BIT;
                thr  = GAMMA_THR[cand*THR_W +: THR_W];
                n_g_val[gb][c] = (thr <= {1'b0, src_idx[c]}) ? cand : src_val[c];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_g_v[gb] <= 1'b0;
            end else if (advance) begin
                r_g_v[gb] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_g_idx[gb]  <= src_idx;
                r_g_val[gb]  <= n_g_val[gb];
                r_g_last[gb] <= src_last;
            end
        end
    end

    // Pack: R in 7:0, G in 15:8, B in 23:16, opaque alpha on top
    assign o_valid      = r_g_v[GS-1];
    assign o_tile_done  = r_g_last[GS-1];
    assign o_pixel_rgba = {rtg_pkg::ALPHA, r_g_val[GS-1][2], r_g_val[GS-1][1],
                           r_g_val[GS-1][0]};

endmodule

@@ hw/rtl/rtg_checker.sv @@
// Port-level checker for the tonemap pipeline, bound to the top level.
module rtg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_pixel_rgba,
    input logic        o_tile_done
);

    // input side is held back only while a finished result is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pixel_rgba) && $stable(o_tile_done)))
        else $error("stalled result changed");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // alpha constant, color channels never reach full scale
    a_pixel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel_rgba[31:24] == rtg_pkg::ALPHA &&
                     o_pixel_rgba[7:0] != 8'hFF && o_pixel_rgba[15:8] != 8'hFF &&
                     o_pixel_rgba[23:16] != 8'hFF))
        else $error("pixel out of range");

endmodule

bind radiance_tonemap_gamma_rgba rtg_checker u_rtg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_pixel_rgba (o_pixel_rgba),
    .o_tile_done  (o_tile_done)
);
